### hw/rtl/shce_pkg.sv
// Shared types and constants of the seed hit chaining engine.
`default_nettype none
package shce_pkg;
    localparam int unsigned SLOT_AW    = 16;
    localparam int unsigned MAX_SLOTS  = 1 << SLOT_AW;
    localparam logic [32:0] ITER_LIMIT = 33'd2147483647;
    localparam logic [20:0] COVER_MAX  = 21'h1FFFFF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    localparam logic [1:0] OP_HIT     = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_REGION  = 2'd2;

    localparam logic [1:0] CFG_KMER_LEN    = 2'd0;
    localparam logic [1:0] CFG_LINK_WINDOW = 2'd1;
    localparam logic [1:0] CFG_MIN_BASES   = 2'd2;
    localparam logic [1:0] CFG_READ_LENGTH = 2'd3;

    // One vertex record as held in the slot store.
    typedef struct packed {
        logic [31:0] timestamp;
        logic [31:0] ref_start;
        logic [31:0] ref_end;
        logic [15:0] query_start;
        logic [16:0] query_end;
        logic [15:0] kmer_count;
        logic [20:0] covered_query;
        logic [20:0] covered_ref;
    } vertex_t;

    localparam int unsigned VERTEX_W = $bits(vertex_t);
endpackage
`default_nettype wire

### hw/rtl/shce_slot_ram.sv
// Slot store: single-port synchronous RAM with a registered read.
`default_nettype none
module shce_slot_ram
    import shce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [SLOT_AW-1:0]   addr,
    input  wire logic [VERTEX_W-1:0]  wdata,
    output logic      [VERTEX_W-1:0]  rdata
);
    logic [VERTEX_W-1:0] mem [MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hw/rtl/seed_hit_chaining_engine_core.sv
// Top level of the seed hit chaining engine.
`default_nettype none
// A seed hit with query_pos below the effective read length keeps busy high from the
// accepting edge: the scan issues one store read per slot, over min(link_window,
// query_pos) slots, through the single port of the slot store, then judges the last
// read. The chosen vertex is then read back in the fetch and wait states, and the
// write state writes the new vertex. The result is strobed by result_valid for one cycle,
// in the first cycle with busy low. The receiver cannot stall it. Advance and end of
// region raise no busy cycles. The exception is an end of region that clears the
// store: it keeps busy high while it clears one slot a cycle. After reset, a
// clearing pass over all 65536 slots runs with busy high. At most one result comes per
// hit. Configuration writes are always taken.
module seed_hit_chaining_engine_core
    import shce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] query_pos,
    input  wire logic [31:0] ref_pos,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             result_valid,
    output logic             anchor_found,
    output logic             chained,
    output logic [15:0]      vertex_slot,
    output logic [31:0]      anchor_ref_start,
    output logic [31:0]      anchor_ref_end,
    output logic [15:0]      anchor_query_start,
    output logic [16:0]      anchor_query_end,
    output logic [15:0]      kmer_count,
    output logic [20:0]      covered_query,
    output logic [20:0]      covered_ref
);
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  k_reg;
    logic [6:0]  win_reg;
    logic [20:0] minb_reg;
    logic [16:0] len_reg;
    logic [31:0] iter_reg, iter_next;

    logic [SLOT_AW-1:0] clr_reg, clr_next;
    logic [15:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [SLOT_AW-1:0] pos_reg, pos_next;
    logic [6:0]  span_reg, span_next;
    logic [7:0]  idx_reg, idx_next;       // offset of slot being issued
    logic [6:0]  chk_reg, chk_next;       // offset of slot whose data returns
    logic        chkv_reg, chkv_next;
    logic [15:0] best_len_reg, best_len_next;
    logic [6:0]  best_off_reg, best_off_next;
    logic        found_reg, found_next;

    logic                we;
    logic [SLOT_AW-1:0]  addr;
    logic [VERTEX_W-1:0] wdata, rdata;
    vertex_t             rv, nv;

    logic [16:0] n_eff;
    logic [6:0]  span_calc;
    logic [31:0] ts_gap;
    logic        qual;
    logic [32:0] region_sum;

    logic [39:0] step_r, sr, sq, cq_sum, cr_sum;
    logic        anchor_calc;

    shce_slot_ram u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign rv        = vertex_t'(rdata);
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign n_eff     = (len_reg > 17'(MAX_SLOTS)) ? 17'(MAX_SLOTS) : len_reg;
    assign span_calc = ({9'd0, win_reg} < query_pos) ? win_reg : query_pos[6:0];
    assign region_sum = {1'b0, iter_reg} + {25'd0, win_reg, 1'b0};
    assign ts_gap    = iter_reg - rv.timestamp;
    assign qual      = (rv.timestamp <= iter_reg) && (ts_gap != 32'd0)
                       && (ts_gap <= {25'd0, win_reg})
                       && (rv.kmer_count != 16'd0) && (rv.kmer_count > best_len_reg);

    // Extension arithmetic on the chosen vertex, signed 40-bit.
    always_comb
    begin
        step_r = {8'd0, r_reg} - ({8'd0, rv.ref_end} - {34'd0, k_reg});
        sr = ($signed(step_r) < $signed({34'd0, k_reg})) ? step_r : {34'd0, k_reg};
        sq = (best_off_reg < {1'b0, k_reg}) ? {33'd0, best_off_reg} : {34'd0, k_reg};
        cq_sum = {19'd0, rv.covered_query} + sq;
        cr_sum = {19'd0, rv.covered_ref} + sr;
    end

    always_comb
    begin
        nv.timestamp = iter_reg;
        nv.ref_end   = r_reg + {26'd0, k_reg};
        nv.query_end = {1'b0, q_reg} + {11'd0, k_reg};
        if (found_reg)
        begin
            nv.ref_start   = rv.ref_start;
            nv.query_start = rv.query_start;
            nv.kmer_count  = (rv.kmer_count == COUNT_MAX) ? COUNT_MAX
                                                          : rv.kmer_count + 16'd1;
            priority if ($signed(cq_sum) < 0) nv.covered_query = 21'd0;
            else if ($signed(cq_sum) > $signed({19'd0, COVER_MAX}))
                nv.covered_query = COVER_MAX;
            else nv.covered_query = cq_sum[20:0];
            priority if ($signed(cr_sum) < 0) nv.covered_ref = 21'd0;
            else if ($signed(cr_sum) > $signed({19'd0, COVER_MAX}))
                nv.covered_ref = COVER_MAX;
            else nv.covered_ref = cr_sum[20:0];
        end
        else
        begin
            nv.ref_start     = r_reg;
            nv.query_start   = q_reg;
            nv.kmer_count    = 16'd1;
            nv.covered_query = {15'd0, k_reg};
            nv.covered_ref   = {15'd0, k_reg};
        end
        anchor_calc = found_reg && (nv.covered_query >= minb_reg)
                      && (nv.covered_ref >= minb_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        clr_next      = clr_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        pos_next      = pos_reg;
        span_next     = span_reg;
        idx_next      = idx_reg;
        chk_next      = chk_reg;
        chkv_next     = 1'b0;
        best_len_next = best_len_reg;
        best_off_next = best_off_reg;
        found_next    = found_reg;
        we            = 1'b0;
        addr          = pos_reg;
        wdata         = nv;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                addr     = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_AW'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_ADVANCE: iter_next = iter_reg + 32'd1;
                        OP_REGION:
                        begin
                            if (region_sum > ITER_LIMIT)
                            begin
                                iter_next  = '0;
                                clr_next   = '0;
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                iter_next = region_sum[31:0];
                            end
                        end
                        OP_HIT:
                        begin
                            if ({1'b0, query_pos} < n_eff)
                            begin
                                q_next        = query_pos;
                                r_next        = ref_pos;
                                pos_next      = SLOT_AW'(n_eff - {1'b0, query_pos} - 17'd1);
                                span_next     = span_calc;
                                idx_next      = 8'd1;
                                best_len_next = '0;
                                best_off_next = '0;
                                found_next    = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle, evaluate the previous one.
                if (chkv_reg && qual)
                begin
                    best_len_next = rv.kmer_count;
                    best_off_next = chk_reg;
                    found_next    = 1'b1;
                end
                if (idx_reg <= {1'b0, span_reg})
                begin
                    addr      = pos_reg + SLOT_AW'(idx_reg);
                    chk_next  = idx_reg[6:0];
                    chkv_next = 1'b1;
                    idx_next  = idx_reg + 8'd1;
                end
                else if (!chkv_reg)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                addr       = pos_reg + SLOT_AW'(best_off_reg);
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // Hold the address so the chosen vertex stays on the read data.
                addr       = pos_reg + SLOT_AW'(best_off_reg);
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                we         = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            iter_reg  <= '0;
            clr_reg   <= '0;
            chkv_reg  <= 1'b0;
            k_reg     <= 6'd6;
            win_reg   <= 7'd9;
            minb_reg  <= 21'd12;
            len_reg   <= 17'd65536;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            clr_reg   <= clr_next;
            chkv_reg  <= chkv_next;
            result_valid <= (state_reg == ST_WRITE);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_KMER_LEN:    k_reg    <= cfg_data[5:0];
                    CFG_LINK_WINDOW: win_reg  <= cfg_data[6:0];
                    CFG_MIN_BASES:   minb_reg <= cfg_data[20:0];
                    CFG_READ_LENGTH: len_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        r_reg        <= r_next;
        pos_reg      <= pos_next;
        span_reg     <= span_next;
        idx_reg      <= idx_next;
        chk_reg      <= chk_next;
        best_len_reg <= best_len_next;
        best_off_reg <= best_off_next;
        found_reg    <= found_next;
        if (state_reg == ST_WRITE)
        begin
            anchor_found       <= anchor_calc;
            chained            <= found_reg;
            vertex_slot        <= pos_reg;
            anchor_ref_start   <= nv.ref_start;
            anchor_ref_end     <= nv.ref_end;
            anchor_query_start <= nv.query_start;
            anchor_query_end   <= nv.query_end;
            kmer_count         <= nv.kmer_count;
            covered_query      <= nv.covered_query;
            covered_ref        <= nv.covered_ref;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/shce_checker.sv
// Port-level checker for the seed hit chaining engine, with its bind.
`default_nettype none
module shce_checker
    import shce_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        result_valid,
    input wire logic        anchor_found,
    input wire logic        chained,
    input wire logic [15:0] kmer_count
);
    // A new vertex never reports an anchor.
    a_anchor_chained: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && anchor_found |-> chained) else $error("anchor on new vertex");
    // New vertex counts one k-mer; chained more.
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !chained |-> kmer_count == 16'd1) else $error("bad new count");
    a_chain_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && chained |-> kmer_count >= 16'd2) else $error("bad chain count");
    // Results arrive as the engine drops busy, never while idle.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)) else $error("result without work");
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("back-to-back results");
endmodule

bind seed_hit_chaining_engine_core shce_checker u_shce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .anchor_found (anchor_found),
    .chained      (chained),
    .kmer_count   (kmer_count)
);
`default_nettype wire
